// ===== rtl/subnet_direction_rate_meter_unit_defines.svh =====
// Assertion macros for the top RTL file of the subnet direction rate meter.
`ifndef SUBNET_DIRECTION_RATE_METER_UNIT_DEFINES_SVH
`define SUBNET_DIRECTION_RATE_METER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdrm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdrm: next-cycle check failed");

`endif

// ===== rtl/sdrm_pkg.sv =====
`default_nettype none

package sdrm_pkg;

    localparam int COUNT_WIDTH     = 40;
    localparam int OUT_WIDTH       = 40;
    localparam int ADDR_WIDTH      = 32;
    localparam int LEN_WIDTH       = 16;
    localparam int ETYPE_WIDTH     = 16;
    localparam int MS_WIDTH        = 32;
    localparam int IVL_WIDTH       = 16;
    localparam int DIR_WIDTH       = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int RATE_SEL_WIDTH  = 2;
    localparam int NUM_RATES       = 4;

    // Multiplying by 1000 adds at most 10 bits.
    localparam int PROD_WIDTH = COUNT_WIDTH + 10;
    localparam int STEP_WIDTH = $clog2(PROD_WIDTH);

    // 1000 = 1024 - 32 + 8
    localparam int MUL_SHIFT_HI  = 10;
    localparam int MUL_SHIFT_MID = 5;
    localparam int MUL_SHIFT_LO  = 3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [IVL_WIDTH-1:0]   INTERVAL_RESET = IVL_WIDTH'(1000);
    localparam logic [ETYPE_WIDTH-1:0] ETHERTYPE_IPV4 = 16'h0800;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NET_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NET_MASK    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INTERVAL    = 2'd2;

    localparam logic [RATE_SEL_WIDTH-1:0] RATE_TOTAL    = 2'd0;
    localparam logic [RATE_SEL_WIDTH-1:0] RATE_INBOUND  = 2'd1;
    localparam logic [RATE_SEL_WIDTH-1:0] RATE_OUTBOUND = 2'd2;
    localparam logic [RATE_SEL_WIDTH-1:0] RATE_LOCAL    = 2'd3;

    localparam logic [DIR_WIDTH-1:0] DIR_LOCAL    = 3'd0;
    localparam logic [DIR_WIDTH-1:0] DIR_OUTBOUND = 3'd1;
    localparam logic [DIR_WIDTH-1:0] DIR_INBOUND  = 3'd2;
    localparam logic [DIR_WIDTH-1:0] DIR_EXTERNAL = 3'd3;
    localparam logic [DIR_WIDTH-1:0] DIR_NONE     = 3'd4;

    typedef struct packed {
        logic                   cmd;
        logic [ETYPE_WIDTH-1:0] frame_type;
        logic [ADDR_WIDTH-1:0]  src_addr;
        logic [ADDR_WIDTH-1:0]  dst_addr;
        logic [LEN_WIDTH-1:0]   wire_length;
    } t_item;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] total_rate;
        logic [OUT_WIDTH-1:0] inbound_rate;
        logic [OUT_WIDTH-1:0] outbound_rate;
        logic [OUT_WIDTH-1:0] local_rate;
        logic [DIR_WIDTH-1:0] direction;
        logic                 window_closed;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Saturating add of a packet length to a window counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [LEN_WIDTH-1:0]   len
    );
        logic [COUNT_WIDTH:0] sum;
        begin
            sum = {1'b0, a} + (COUNT_WIDTH + 1)'(len);
            return sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
        end
    endfunction

    // Clamp a counter-wide rate to the output field width.
    function automatic logic [OUT_WIDTH-1:0] out_sat(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+OUT_WIDTH-1:0] wide;
        logic [COUNT_WIDTH+OUT_WIDTH-1:0] lim;
        begin
            wide = (COUNT_WIDTH + OUT_WIDTH)'(v);
            lim  = (COUNT_WIDTH + OUT_WIDTH)'({OUT_WIDTH{1'b1}});
            return (wide > lim) ? {OUT_WIDTH{1'b1}} : wide[OUT_WIDTH-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdrm_classify.sv =====
`default_nettype none

// Sorts an IPv4 packet by whether its source and destination lie in the local subnet.
module sdrm_classify (
    input  wire logic [sdrm_pkg::ETYPE_WIDTH-1:0] i_frame_type,
    input  wire logic [sdrm_pkg::ADDR_WIDTH-1:0]  i_src_addr,
    input  wire logic [sdrm_pkg::ADDR_WIDTH-1:0]  i_dst_addr,
    input  wire logic [sdrm_pkg::ADDR_WIDTH-1:0]  i_net_address,
    input  wire logic [sdrm_pkg::ADDR_WIDTH-1:0]  i_net_mask,
    output logic      [sdrm_pkg::DIR_WIDTH-1:0]   o_direction
);

    logic src_in;
    logic dst_in;

    assign src_in = (i_src_addr & i_net_mask) == i_net_address;
    assign dst_in = (i_dst_addr & i_net_mask) == i_net_address;

    always_comb begin
        if (i_frame_type != sdrm_pkg::ETHERTYPE_IPV4) begin
            o_direction = sdrm_pkg::DIR_NONE;
        end else if (src_in && dst_in) begin
            o_direction = sdrm_pkg::DIR_LOCAL;
        end else if (src_in) begin
            o_direction = sdrm_pkg::DIR_OUTBOUND;
        end else if (dst_in) begin
            o_direction = sdrm_pkg::DIR_INBOUND;
        end else begin
            o_direction = sdrm_pkg::DIR_EXTERNAL;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sdrm_divider.sv =====
`default_nettype none

// Shared rate unit: multiplies a byte count by 1000 in two add steps, then
// divides by the elapsed milliseconds one quotient bit per cycle.
module sdrm_divider (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [sdrm_pkg::COUNT_WIDTH-1:0]   i_dividend,
    input  wire logic [sdrm_pkg::MS_WIDTH-1:0]      i_divisor,
    output logic      [sdrm_pkg::COUNT_WIDTH-1:0]   o_quotient,
    output sdrm_pkg::t_div_status                   o_status
);

    localparam int PW = sdrm_pkg::PROD_WIDTH;
    localparam int MW = sdrm_pkg::MS_WIDTH;

    typedef enum logic [4:0] {
        DV_IDLE  = 5'b00001,
        DV_MUL_A = 5'b00010,
        DV_MUL_B = 5'b00100,
        DV_STEP  = 5'b01000,
        DV_DONE  = 5'b10000
    } t_dv_state;

    t_dv_state                             r_state, n_state;
    logic [sdrm_pkg::COUNT_WIDTH-1:0]      r_src, n_src;
    logic [MW-1:0]                         r_div, n_div;
    logic [MW-1:0]                         r_rem, n_rem;
    logic [PW-1:0]                         r_prod, n_prod;
    logic [sdrm_pkg::STEP_WIDTH-1:0]       r_cnt, n_cnt;

    logic [MW:0] shifted;
    logic        fits;

    assign shifted = {r_rem, r_prod[PW-1]};
    assign fits    = shifted >= {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        n_div   = r_div;
        n_rem   = r_rem;
        n_prod  = r_prod;
        n_cnt   = r_cnt;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_src   = i_dividend;
                    n_div   = i_divisor;
                    n_rem   = '0;
                    n_cnt   = sdrm_pkg::STEP_WIDTH'(PW - 1);
                    n_state = DV_MUL_A;
                end
            end
            DV_MUL_A: begin
                n_prod  = (PW'(r_src) << sdrm_pkg::MUL_SHIFT_HI)
                        - (PW'(r_src) << sdrm_pkg::MUL_SHIFT_MID);
                n_state = DV_MUL_B;
            end
            DV_MUL_B: begin
                n_prod  = r_prod + (PW'(r_src) << sdrm_pkg::MUL_SHIFT_LO);
                n_state = DV_STEP;
            end
            DV_STEP: begin
                // The remainder stays below the divisor, so it fits MW bits.
                n_rem  = fits ? MW'(shifted - {1'b0, r_div}) : shifted[MW-1:0];
                n_prod = {r_prod[PW-2:0], fits};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_src  <= n_src;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_prod <= n_prod;
        r_cnt  <= n_cnt;
    end

    assign o_quotient    = (r_prod > PW'(sdrm_pkg::COUNT_MAX))
                         ? sdrm_pkg::COUNT_MAX : r_prod[sdrm_pkg::COUNT_WIDTH-1:0];
    assign o_status.busy = r_state != DV_IDLE;
    assign o_status.done = r_state == DV_DONE;

endmodule

`default_nettype wire

// ===== rtl/subnet_direction_rate_meter_unit.sv =====
`default_nettype none

// Subnet direction rate meter. Each input transaction is either a packet
// descriptor or a one millisecond tick, and each produces exactly one result
// transaction carrying the current total, inbound, outbound and local byte
// rates, the packet's direction and a flag that marks a closed window. A tick
// or a packet that does not close a window passes through the execute and
// output states before the block is ready again. A packet that arrives after
// more than update_interval_ms ticks closes the window: the four rates are
// then worked out one after another by a single shared multiply-by-1000 and
// restoring divide unit, which runs a start, two add steps for the multiply,
// 50 quotient bits and a finish for each rate. A finished result waits in an
// output register while the next transaction is accepted. Configuration
// registers (subnet address, subnet mask, interval) are written through a
// plain write port and take effect on the next transaction; write them only
// while the block is idle.
module subnet_direction_rate_meter_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire sdrm_pkg::t_item                        i_item,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output sdrm_pkg::t_result                           o_result,
    input  wire logic                                   i_cfg_we,
    input  wire logic [sdrm_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  wire logic [sdrm_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);

`include "subnet_direction_rate_meter_unit_defines.svh"

    localparam int CW = sdrm_pkg::COUNT_WIDTH;
    localparam int MW = sdrm_pkg::MS_WIDTH;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_EXEC      = 5'b00010,
        ST_DIV_START = 5'b00100,
        ST_DIV_WAIT  = 5'b01000,
        ST_OUT       = 5'b10000
    } t_state;

    t_state                                   r_state, n_state;
    sdrm_pkg::t_item                          r_item;

    // Configuration registers.
    logic [sdrm_pkg::ADDR_WIDTH-1:0]          r_net_address;
    logic [sdrm_pkg::ADDR_WIDTH-1:0]          r_net_mask;
    logic [sdrm_pkg::IVL_WIDTH-1:0]           r_interval;

    // Window state and rate registers.
    logic [MW-1:0]                            r_elapsed_ms, n_elapsed_ms;
    logic [CW-1:0]                            r_total, n_total;
    logic [CW-1:0]                            r_in, n_in;
    logic [CW-1:0]                            r_out, n_out;
    logic [CW-1:0]                            r_local, n_local;
    logic [CW-1:0]                            r_rate [sdrm_pkg::NUM_RATES];
    logic [sdrm_pkg::RATE_SEL_WIDTH-1:0]      r_sel, n_sel;

    // Per-transaction result bits and the output register.
    logic [sdrm_pkg::DIR_WIDTH-1:0]           r_dir, n_dir;
    logic                                     r_closed, n_closed;
    logic                                     r_out_valid, n_out_valid;
    sdrm_pkg::t_result                        r_result;

    logic [sdrm_pkg::DIR_WIDTH-1:0]           cls_dir;
    logic [CW-1:0]                            total_add;
    logic [CW-1:0]                            len_ext;
    logic [CW-1:0]                            div_dividend;
    logic [CW-1:0]                            div_quotient;
    logic                                     div_start;
    sdrm_pkg::t_div_status                    div_stat;
    logic                                     rate_we;
    logic                                     out_load;
    logic                                     in_fire;

    sdrm_classify u_classify (
        .i_frame_type  (r_item.frame_type),
        .i_src_addr    (r_item.src_addr),
        .i_dst_addr    (r_item.dst_addr),
        .i_net_address (r_net_address),
        .i_net_mask    (r_net_mask),
        .o_direction   (cls_dir)
    );

    sdrm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_elapsed_ms),
        .o_quotient (div_quotient),
        .o_status   (div_stat)
    );

    assign o_in_ready = r_state == ST_IDLE;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign total_add  = sdrm_pkg::sat_add(r_total, r_item.wire_length);
    assign len_ext    = CW'(r_item.wire_length);
    assign div_start  = r_state == ST_DIV_START;
    assign rate_we    = (r_state == ST_DIV_WAIT) && div_stat.done;

    // The divider works through the counters in rate register order.
    always_comb begin
        case (r_sel)
            sdrm_pkg::RATE_TOTAL:    div_dividend = r_total;
            sdrm_pkg::RATE_INBOUND:  div_dividend = r_in;
            sdrm_pkg::RATE_OUTBOUND: div_dividend = r_out;
            sdrm_pkg::RATE_LOCAL:    div_dividend = r_local;
            default:                 div_dividend = r_total;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_elapsed_ms = r_elapsed_ms;
        n_total      = r_total;
        n_in         = r_in;
        n_out        = r_out;
        n_local      = r_local;
        n_sel        = r_sel;
        n_dir        = r_dir;
        n_closed     = r_closed;
        n_out_valid  = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_item.cmd == sdrm_pkg::CMD_TICK) begin
                    // Ticks only advance time; they never close a window.
                    if (r_elapsed_ms != {MW{1'b1}}) begin
                        n_elapsed_ms = r_elapsed_ms + 1'b1;
                    end
                    n_dir    = sdrm_pkg::DIR_NONE;
                    n_closed = 1'b0;
                    n_state  = ST_OUT;
                end else begin
                    n_total = total_add;
                    n_dir   = cls_dir;
                    if (r_elapsed_ms > MW'(r_interval)) begin
                        // The closing packet's bytes count in the old total.
                        n_closed = 1'b1;
                        n_sel    = sdrm_pkg::RATE_TOTAL;
                        n_state  = ST_DIV_START;
                    end else begin
                        n_closed = 1'b0;
                        case (cls_dir)
                            sdrm_pkg::DIR_LOCAL:
                                n_local = sdrm_pkg::sat_add(r_local, r_item.wire_length);
                            sdrm_pkg::DIR_OUTBOUND:
                                n_out = sdrm_pkg::sat_add(r_out, r_item.wire_length);
                            sdrm_pkg::DIR_INBOUND:
                                n_in = sdrm_pkg::sat_add(r_in, r_item.wire_length);
                            default: begin
                                n_total = total_add;
                            end
                        endcase
                        n_state = ST_OUT;
                    end
                end
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    if (r_sel == sdrm_pkg::RATE_LOCAL) begin
                        // Restart the window; the closing packet's direction
                        // bytes open the new one.
                        n_elapsed_ms = '0;
                        n_total      = '0;
                        n_in    = (r_dir == sdrm_pkg::DIR_INBOUND)  ? len_ext : '0;
                        n_out   = (r_dir == sdrm_pkg::DIR_OUTBOUND) ? len_ext : '0;
                        n_local = (r_dir == sdrm_pkg::DIR_LOCAL)    ? len_ext : '0;
                        n_state = ST_OUT;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = ST_DIV_START;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_net_address <= '0;
            r_net_mask    <= '0;
            r_interval    <= sdrm_pkg::INTERVAL_RESET;
            r_elapsed_ms  <= '0;
            r_total       <= '0;
            r_in          <= '0;
            r_out         <= '0;
            r_local       <= '0;
            r_sel         <= sdrm_pkg::RATE_TOTAL;
            r_dir         <= sdrm_pkg::DIR_NONE;
            r_closed      <= 1'b0;
            for (int i = 0; i < sdrm_pkg::NUM_RATES; i++) begin
                r_rate[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_elapsed_ms <= n_elapsed_ms;
            r_total      <= n_total;
            r_in         <= n_in;
            r_out        <= n_out;
            r_local      <= n_local;
            r_sel        <= n_sel;
            r_dir        <= n_dir;
            r_closed     <= n_closed;
            if (rate_we) begin
                r_rate[r_sel] <= div_quotient;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdrm_pkg::CFG_NET_ADDRESS: begin
                        r_net_address <= i_cfg_data[sdrm_pkg::ADDR_WIDTH-1:0];
                    end
                    sdrm_pkg::CFG_NET_MASK: begin
                        r_net_mask <= i_cfg_data[sdrm_pkg::ADDR_WIDTH-1:0];
                    end
                    sdrm_pkg::CFG_INTERVAL: begin
                        r_interval <= i_cfg_data[sdrm_pkg::IVL_WIDTH-1:0];
                    end
                    default: begin
                        r_interval <= r_interval;
                    end
                endcase
            end
        end
    end

    // The input transaction and the result are payload and need no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_item;
        end
        if (out_load) begin
            r_result.total_rate    <= sdrm_pkg::out_sat(r_rate[sdrm_pkg::RATE_TOTAL]);
            r_result.inbound_rate  <= sdrm_pkg::out_sat(r_rate[sdrm_pkg::RATE_INBOUND]);
            r_result.outbound_rate <= sdrm_pkg::out_sat(r_rate[sdrm_pkg::RATE_OUTBOUND]);
            r_result.local_rate    <= sdrm_pkg::out_sat(r_rate[sdrm_pkg::RATE_LOCAL]);
            r_result.direction     <= r_dir;
            r_result.window_closed <= r_closed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // The shared divider runs only while the sequencer waits on it.
    `SDRM_ASSERT_SAME(a_div_busy_in_wait, i_clk, i_rst_n,
        div_stat.busy, r_state == ST_DIV_WAIT)
    // An accepted transaction holds off the next one.
    `SDRM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        in_fire, !o_in_ready)
    // A result that reports a closed window leaves the elapsed time cleared.
    `SDRM_ASSERT_NEXT(a_closed_clears_time, i_clk, i_rst_n,
        out_load && r_closed, r_elapsed_ms == '0)

endmodule

`default_nettype wire

// ===== verif/subnet_direction_rate_meter_unit_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the subnet direction rate meter. A software copy of the
// meter follows every accepted input transaction and queues the result that the
// block has to produce for it. Every accepted result transaction is checked
// against the oldest queued result, field by field.
module subnet_direction_rate_meter_unit_test;
    import sdrm_pkg::*;

    // The longest stretch without any accepted transaction that a correct block
    // can cause. A closing packet keeps the block busy while all four rates are
    // worked out, and the long receiver hold below adds to that. This limit is
    // several times the sum of the two.
    localparam int HOLD_CYCLES = 500;
    localparam int QUIET_LIMIT = 5000;

    // After the last result has arrived, wait about as long as a closing packet
    // takes, so that a stray extra result would still be seen.
    localparam int TAIL_CYCLES = 300;

    // The software copy of the meter. It keeps its own window counters, rate
    // registers and register settings, and holds the results still owed by the
    // block in arrival order.
    class rate_meter_tracker;
        logic [ADDR_WIDTH-1:0]  net_address;
        logic [ADDR_WIDTH-1:0]  net_mask;
        logic [IVL_WIDTH-1:0]   interval_ms;
        logic [MS_WIDTH-1:0]    elapsed_ms;
        logic [COUNT_WIDTH-1:0] total_bytes;
        logic [COUNT_WIDTH-1:0] in_bytes;
        logic [COUNT_WIDTH-1:0] out_bytes;
        logic [COUNT_WIDTH-1:0] local_bytes;
        logic [COUNT_WIDTH-1:0] rate_regs [NUM_RATES];
        t_result                pending_rates [$];
        int                     mismatches;

        function new();
            net_address = '0;
            net_mask    = '0;
            interval_ms = INTERVAL_RESET;
            elapsed_ms  = '0;
            total_bytes = '0;
            in_bytes    = '0;
            out_bytes   = '0;
            local_bytes = '0;
            foreach (rate_regs[i]) rate_regs[i] = '0;
            mismatches  = 0;
        endfunction

        // Window counters stick at their maximum instead of wrapping.
        function logic [COUNT_WIDTH-1:0] grow(input logic [COUNT_WIDTH-1:0] acc,
                                              input logic [LEN_WIDTH-1:0] len);
            if (acc > COUNT_MAX - COUNT_WIDTH'(len)) return COUNT_MAX;
            return acc + COUNT_WIDTH'(len);
        endfunction

        // Truncated bytes per second over the closed window.
        function logic [COUNT_WIDTH-1:0] per_second(input logic [COUNT_WIDTH-1:0] bytes,
                                                    input logic [MS_WIDTH-1:0] ms);
            logic [63:0] quotient;
            quotient = (64'(bytes) * 64'd1000) / 64'(ms);
            return (quotient > 64'(COUNT_MAX)) ? COUNT_MAX : quotient[COUNT_WIDTH-1:0];
        endfunction

        function logic [OUT_WIDTH-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
            return (64'(v) > 64'({OUT_WIDTH{1'b1}})) ? {OUT_WIDTH{1'b1}} : OUT_WIDTH'(v);
        endfunction

        function void take_item(input t_item it);
            t_result              want;
            logic                 src_in;
            logic                 dst_in;
            logic [DIR_WIDTH-1:0] dir;
            logic                 closed;
            dir    = DIR_NONE;
            closed = 1'b0;
            if (it.cmd == CMD_TICK) begin
                if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
            end else begin
                // The closing packet still belongs to the old window's total.
                total_bytes = grow(total_bytes, it.wire_length);
                if (elapsed_ms > MS_WIDTH'(interval_ms)) begin
                    rate_regs[RATE_TOTAL]    = per_second(total_bytes, elapsed_ms);
                    rate_regs[RATE_INBOUND]  = per_second(in_bytes, elapsed_ms);
                    rate_regs[RATE_OUTBOUND] = per_second(out_bytes, elapsed_ms);
                    rate_regs[RATE_LOCAL]    = per_second(local_bytes, elapsed_ms);
                    elapsed_ms  = '0;
                    total_bytes = '0;
                    in_bytes    = '0;
                    out_bytes   = '0;
                    local_bytes = '0;
                    closed      = 1'b1;
                end
                // Its direction bytes, though, open the new window.
                if (it.frame_type == ETHERTYPE_IPV4) begin
                    src_in = (it.src_addr & net_mask) == net_address;
                    dst_in = (it.dst_addr & net_mask) == net_address;
                    if (src_in && dst_in) begin
                        dir         = DIR_LOCAL;
                        local_bytes = grow(local_bytes, it.wire_length);
                    end else if (src_in) begin
                        dir       = DIR_OUTBOUND;
                        out_bytes = grow(out_bytes, it.wire_length);
                    end else if (dst_in) begin
                        dir      = DIR_INBOUND;
                        in_bytes = grow(in_bytes, it.wire_length);
                    end else begin
                        dir = DIR_EXTERNAL;
                    end
                end
            end
            want.total_rate    = to_field(rate_regs[RATE_TOTAL]);
            want.inbound_rate  = to_field(rate_regs[RATE_INBOUND]);
            want.outbound_rate = to_field(rate_regs[RATE_OUTBOUND]);
            want.local_rate    = to_field(rate_regs[RATE_LOCAL]);
            want.direction     = dir;
            want.window_closed = closed;
            pending_rates.push_back(want);
        endfunction

        function void flag(input string what, input logic [63:0] want,
                           input logic [63:0] seen);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
        endfunction

        function void check_rates(input t_result got);
            t_result want;
            if (pending_rates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result transaction with nothing expected, direction %0d",
                             $time, got.direction);
            end else begin
                want = pending_rates.pop_front();
                if (got.total_rate !== want.total_rate)
                    flag("total_rate", want.total_rate, got.total_rate);
                if (got.inbound_rate !== want.inbound_rate)
                    flag("inbound_rate", want.inbound_rate, got.inbound_rate);
                if (got.outbound_rate !== want.outbound_rate)
                    flag("outbound_rate", want.outbound_rate, got.outbound_rate);
                if (got.local_rate !== want.local_rate)
                    flag("local_rate", want.local_rate, got.local_rate);
                if (got.direction !== want.direction)
                    flag("direction", want.direction, got.direction);
                if (got.window_closed !== want.window_closed)
                    flag("window_closed", want.window_closed, got.window_closed);
            end
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    t_item                      in_item   = '0;
    logic                       in_ready;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    t_result                    out_result;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_NET_ADDRESS;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    rate_meter_tracker tracker;
    int                results_seen = 0;
    int                quiet_cycles = 0;
    int                burst_left   = 0;
    // Set while the random traffic runs, so that the long receiver hold lands
    // on a stretch in which the sender keeps offering transactions.
    bit                flooding     = 1'b0;

    always #5 clk = ~clk;

    subnet_direction_rate_meter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_item      (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_result    (out_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Both handshakes are sampled at the rising edge, before any of the
    // nonblocking updates of that edge have landed, so the values seen here are
    // the ones the block saw.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) tracker.take_item(in_item);
            if (out_valid && out_ready) begin
                tracker.check_rates(out_result);
                results_seen++;
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a transaction.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver switches between stall rates at random moments, with
    // stretches of no stalling at all. Once during the random traffic it holds
    // off for a long stretch so that the output register fills up and the block
    // has to stall its input while the sender keeps offering.
    initial begin : receiver
        int stall_pct;
        int stretch_left;
        bit held;
        stall_pct    = 0;
        stretch_left = 0;
        held         = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && flooding && results_seen >= 300) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                if (stretch_left == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    stretch_left = $urandom_range(8, 80);
                end
                stretch_left--;
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offers one input transaction and returns at the edge that accepts it. The
    // sender works in bursts; a new burst may start after a random gap with
    // valid low. Valid stays high between transactions of one burst.
    task automatic push_item(input t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops the sender, waits until every owed result has come back, and then
    // lets the block return to idle.
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (tracker.pending_rates.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges; the block must be idle.
    task automatic apply_setting(input logic [ADDR_WIDTH-1:0] addr,
                                 input logic [ADDR_WIDTH-1:0] mask,
                                 input logic [IVL_WIDTH-1:0] ivl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NET_ADDRESS;
        cfg_data  <= CFG_DATA_WIDTH'(addr);
        @(posedge clk);
        cfg_index <= CFG_NET_MASK;
        cfg_data  <= CFG_DATA_WIDTH'(mask);
        @(posedge clk);
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= CFG_DATA_WIDTH'(ivl);
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.net_address = addr;
        tracker.net_mask    = mask;
        tracker.interval_ms = ivl;
    endtask

    function automatic t_item packet_item(input logic [ETYPE_WIDTH-1:0] etype,
                                          input logic [ADDR_WIDTH-1:0] src,
                                          input logic [ADDR_WIDTH-1:0] dst,
                                          input logic [LEN_WIDTH-1:0] len);
        t_item it;
        it.cmd         = CMD_PACKET;
        it.frame_type  = etype;
        it.src_addr    = src;
        it.dst_addr    = dst;
        it.wire_length = len;
        return it;
    endfunction

    // A tick ignores its other fields; they are filled with all zeros or all
    // ones to show that.
    function automatic t_item tick_item(input logic fill);
        t_item it;
        it     = {$bits(t_item){fill}};
        it.cmd = CMD_TICK;
        return it;
    endfunction

    // Random traffic with enough ticks to close windows often at short intervals.
    // Addresses land inside the current subnet half of the time, so all four
    // directions come up wherever the mask is nonzero and covers the address.
    function automatic t_item random_item();
        t_item                 it;
        logic [ADDR_WIDTH-1:0] base;
        int                    tick_pct;
        base     = tracker.net_address & tracker.net_mask;
        tick_pct = (tracker.interval_ms > IVL_WIDTH'(50)) ? 5 : 30;
        it.cmd   = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_PACKET;
        it.frame_type = ($urandom_range(0, 4) == 0) ? ETYPE_WIDTH'($urandom)
                                                    : ETHERTYPE_IPV4;
        it.src_addr = $urandom_range(0, 1) ? (base | ($urandom & ~tracker.net_mask))
                                           : ADDR_WIDTH'($urandom);
        it.dst_addr = $urandom_range(0, 1) ? (base | ($urandom & ~tracker.net_mask))
                                           : ADDR_WIDTH'($urandom);
        case ($urandom_range(0, 9))
            0:       it.wire_length = '0;
            1:       it.wire_length = '1;
            default: it.wire_length = LEN_WIDTH'($urandom);
        endcase
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count) push_item(random_item());
    endtask

    initial begin : stimulus
        logic [ADDR_WIDTH-1:0] prefix_mask;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the mask is zero, so every IPv4 packet is local, and
        // the interval is 1000 ms, so no window closes here.
        push_item(packet_item(ETHERTYPE_IPV4, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        push_item(packet_item(ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        push_item(packet_item(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0001));
        push_item(tick_item(1'b1));
        push_item(tick_item(1'b0));
        settle();

        // A /24 subnet and a zero interval: the first packet after any tick
        // closes the window.
        apply_setting(32'hC0A8_0100, 32'hFFFF_FF00, 16'd0);
        push_item(packet_item(ETHERTYPE_IPV4, 32'hC0A8_0105, 32'hC0A8_01FE, 16'd1500));
        push_item(packet_item(ETHERTYPE_IPV4, 32'hC0A8_01FF, 32'hFFFF_FFFF, 16'hFFFF));
        push_item(packet_item(ETHERTYPE_IPV4, 32'h0000_0000, 32'hC0A8_0100, 16'd64));
        push_item(packet_item(ETHERTYPE_IPV4, 32'h0102_0304, 32'hC0A9_0100, 16'd100));
        push_item(packet_item(16'h0801, 32'hC0A8_0101, 32'hC0A8_0102, 16'd200));
        push_item(packet_item(16'h0000, 32'hC0A8_0101, 32'h0102_0304, 16'd300));
        push_item(tick_item(1'b0));
        // A zero length packet closes a one millisecond window.
        push_item(packet_item(ETHERTYPE_IPV4, 32'hC0A8_0110, 32'hC0A8_0111, 16'h0000));
        push_item(packet_item(ETHERTYPE_IPV4, 32'hC0A8_0120, 32'h0808_0808, 16'hFFFF));
        push_item(packet_item(ETHERTYPE_IPV4, 32'h0808_0808, 32'hC0A8_0120, 16'hFFFF));
        push_item(packet_item(ETHERTYPE_IPV4, 32'hC0A8_0130, 32'hC0A8_0131, 16'hFFFF));
        push_item(tick_item(1'b1));
        // Closing over one millisecond with full length packets gives high rates.
        push_item(packet_item(ETHERTYPE_IPV4, 32'h0808_0808, 32'h0404_0404, 16'hFFFF));
        push_item(tick_item(1'b0));
        push_item(tick_item(1'b1));
        // A packet that is not IPv4 can close a window as well.
        push_item(packet_item(16'h86DD, 32'hC0A8_0101, 32'hC0A8_0102, 16'hFFFF));
        settle();

        flooding = 1'b1;
        apply_setting(32'hC0A8_0100, 32'hFFFF_FF00, 16'd3);
        run_random(250);
        settle();

        apply_setting(32'h0A00_0000, 32'hFF00_0000, 16'd1);
        run_random(250);
        settle();

        // Only the all-ones host is inside the subnet.
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
        run_random(200);
        settle();

        apply_setting(32'h0000_0000, 32'h0000_0000, 16'd10);
        run_random(200);
        settle();

        prefix_mask = {ADDR_WIDTH{1'b1}} << $urandom_range(0, ADDR_WIDTH);
        apply_setting(ADDR_WIDTH'($urandom), prefix_mask, IVL_WIDTH'($urandom_range(2, 8)));
        run_random(200);
        settle();

        // The address has bits outside a zero mask, so nothing ever matches and
        // every IPv4 packet is external.
        apply_setting(32'h1234_5678, 32'h0000_0000, 16'd2);
        run_random(100);
        settle();

        // The widest interval: no window closes in this phase.
        apply_setting(32'hAC10_0000, 32'hFFF0_0000, 16'hFFFF);
        run_random(50);
        settle();
        flooding = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_rates.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
